@@ rtl/core/ufmc_pkg.sv @@
package ufmc_pkg;

   // Grid size built into the cell stores
   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 32;
   localparam int CELLS    = MAX_ROWS * MAX_COLS;
   localparam int CELL_W   = $clog2(CELLS);
   localparam int SIZE_W   = $clog2(CELLS + 1);
   localparam int OPND_W   = SIZE_W;

   // Field widths of the items
   localparam int ROW_W   = 5;
   localparam int COL_W   = 5;
   localparam int GRID_W  = 6;
   localparam int EDGE_W  = 11;
   localparam int MSIZE_W = 11;
   localparam logic [MSIZE_W-1:0] MSIZE_MAX = '1;

   // Register reset values
   localparam logic [GRID_W-1:0] GRID_ROWS_RST  = 6'd32;
   localparam logic [GRID_W-1:0] GRID_COLS_RST  = 6'd32;
   localparam logic [EDGE_W-1:0] EDGE_COUNT_RST = 11'd1984;

   // Port widths
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 3;

   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [OPND_W-1:0] opnd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_A,
      ST_WALK_B,
      ST_DECIDE,
      ST_MERGE,
      ST_FINISH
   } state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_ROWS  = 2'd0,
      CSR_GRID_COLS  = 2'd1,
      CSR_EDGE_COUNT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      WALL_NONE  = 2'd0,
      WALL_BELOW = 2'd1,
      WALL_RIGHT = 2'd2
   } wall_kind_type;

   // Write side of the parent and size stores
   typedef struct packed {
      logic     parent_we;
      cell_type parent_addr;
      cell_type parent_data;
      logic     size_we;
      cell_type size_addr;
      size_type size_data;
   } store_wr_type;

   // Flat cell index: row-major over the built column count
   function automatic cell_type cell_index(input logic [ROW_W-1:0] row,
                                           input logic [COL_W-1:0] col);
      cell_index = CELL_W'(int'(row) * MAX_COLS + int'(col));
   endfunction

endpackage

@@ rtl/core/ufmc_link_store.sv @@
module ufmc_link_store (
   input  logic                  clock,
   input  ufmc_pkg::cell_type     rd_addr,
   output ufmc_pkg::cell_type     rd_parent,
   output ufmc_pkg::size_type     rd_size,
   input  ufmc_pkg::store_wr_type wr
);
   import ufmc_pkg::*;

   cell_type parent_mem [CELLS];
   size_type size_mem [CELLS];
   cell_type rd_parent_ff;
   size_type rd_size_ff;

   // Write the parent links
   always_ff @(posedge clock) begin
      if (wr.parent_we) begin
         parent_mem[wr.parent_addr] <= wr.parent_data;
      end
   end

   // Write the set sizes
   always_ff @(posedge clock) begin
      if (wr.size_we) begin
         size_mem[wr.size_addr] <= wr.size_data;
      end
   end

   // Read both stores at one address, data registered
   always_ff @(posedge clock) begin
      rd_parent_ff <= parent_mem[rd_addr];
      rd_size_ff   <= size_mem[rd_addr];
   end

   assign rd_parent = rd_parent_ff;
   assign rd_size   = rd_size_ff;

endmodule

@@ rtl/core/ufmc_alu.sv @@
module ufmc_alu (
   input  ufmc_pkg::opnd_type op_a,
   input  ufmc_pkg::opnd_type op_b,
   output logic              eq,
   output logic              lt,
   output ufmc_pkg::opnd_type sum
);
   import ufmc_pkg::*;

   // Compare and add; a set sum never exceeds the cell count
   assign eq  = (op_a == op_b);
   assign lt  = (op_a < op_b);
   assign sum = op_a + op_b;

endmodule

@@ rtl/core/union_find_maze_carver_unit.sv @@
// Kruskal maze carver: each item is one grid edge (cell a, cell b) in weight order, and each
// gives exactly one result naming the merge and the wall to clear. Roots are found by walking
// parent links one link per clock through a single read port on the parent/size store; union
// by size keeps every tree at most log2(MAX_ROWS*MAX_COLS) links deep (10 for 32x32). An item
// walks from cell a and then from cell b to their roots and merges the two sets unless they
// already share a root; an item with an endpoint outside the grid skips the walks. Each item
// holds the block until its result enters the result register; req_tready is high only
// between items. The result register lets the next item enter while a result still waits on
// rsp_tready. After reset a clearing pass over all MAX_ROWS*MAX_COLS cells (1024) sets every
// cell to its own root of size one, with req_tready low; register writes are taken throughout
// and never disturb the sets.
module union_find_maze_carver_unit (
   input  logic                               clock,
   input  logic                               reset,
   // Edge items
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ufmc_pkg::REQ_TDATA_W-1:0]   req_tdata,  // a_row, a_col, b_row, b_col
   // Results
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ufmc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // joined, wall_row, wall_col,
                                                          // merged_size
   output logic [ufmc_pkg::RSP_TUSER_W-1:0]   rsp_tuser,  // wall_kind, bad_cell
   output logic                               rsp_tlast,  // last_edge
   // Register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ufmc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ufmc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ufmc_pkg::*;

   localparam cell_type CELL_LAST = CELL_W'(CELLS - 1);

   state_type state_ff, state_in;
   cell_type  clr_idx_ff, clr_idx_in;
   cell_type  cur_ff, cur_in;
   cell_type  root_a_ff, root_a_in;
   cell_type  root_b_ff, root_b_in;
   size_type  size_a_ff, size_a_in;
   size_type  size_b_ff, size_b_in;
   size_type  msize_ff, msize_in;
   logic      bad_ff, bad_in;
   logic      joined_ff, joined_in;
   logic [ROW_W-1:0] a_row_ff, a_row_in, b_row_ff, b_row_in;
   logic [COL_W-1:0] a_col_ff, a_col_in, b_col_ff, b_col_in;
   logic [EDGE_W-1:0] edges_seen_ff, edges_seen_in;
   logic [GRID_W-1:0] grid_rows_ff, grid_cols_ff;
   logic [EDGE_W-1:0] edge_count_ff;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_TUSER_W-1:0] rsp_tuser_ff, rsp_tuser_in;
   logic                   rsp_tlast_ff, rsp_tlast_in;

   logic             req_accept;
   logic             out_free;
   logic [ROW_W-1:0] in_ar, in_br;
   logic [COL_W-1:0] in_ac, in_bc;
   logic             in_bad;
   cell_type         ca_req, cb_lat;
   cell_type         rd_addr, rd_parent;
   size_type         rd_size;
   store_wr_type     wr;
   opnd_type         alu_a, alu_b, alu_sum;
   logic             alu_eq, alu_lt;
   logic [ROW_W:0]   ar_inc, br_inc;
   logic [COL_W:0]   ac_inc, bc_inc;
   logic             vert_adj, horz_adj;
   wall_kind_type    wall_kind;
   logic [ROW_W-1:0] wall_row;
   logic [COL_W-1:0] wall_col;
   logic [MSIZE_W-1:0] msize_out;
   logic             last_hit;

   // Unpack the edge item
   assign in_ar = req_tdata[ROW_W-1:0];
   assign in_ac = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign in_br = req_tdata[2*ROW_W+COL_W-1:ROW_W+COL_W];
   assign in_bc = req_tdata[2*ROW_W+2*COL_W-1:2*ROW_W+COL_W];

   // Endpoint outside min(register, built size) means outside either one
   assign in_bad = (32'(in_ar) >= 32'(grid_rows_ff)) || (32'(in_ar) >= 32'(MAX_ROWS)) ||
                   (32'(in_br) >= 32'(grid_rows_ff)) || (32'(in_br) >= 32'(MAX_ROWS)) ||
                   (32'(in_ac) >= 32'(grid_cols_ff)) || (32'(in_ac) >= 32'(MAX_COLS)) ||
                   (32'(in_bc) >= 32'(grid_cols_ff)) || (32'(in_bc) >= 32'(MAX_COLS));

   assign ca_req = cell_index(in_ar, in_ac);
   assign cb_lat = cell_index(b_row_ff, b_col_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   ufmc_link_store u_store (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .rd_parent (rd_parent),
      .rd_size   (rd_size),
      .wr        (wr)
   );

   ufmc_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .eq   (alu_eq),
      .lt   (alu_lt),
      .sum  (alu_sum)
   );

   // Wall between the endpoints, only when a merge took place
   assign ar_inc   = {1'b0, a_row_ff} + 1'b1;
   assign br_inc   = {1'b0, b_row_ff} + 1'b1;
   assign ac_inc   = {1'b0, a_col_ff} + 1'b1;
   assign bc_inc   = {1'b0, b_col_ff} + 1'b1;
   assign vert_adj = (a_col_ff == b_col_ff) &&
                     ((ar_inc == {1'b0, b_row_ff}) || (br_inc == {1'b0, a_row_ff}));
   assign horz_adj = (a_row_ff == b_row_ff) &&
                     ((ac_inc == {1'b0, b_col_ff}) || (bc_inc == {1'b0, a_col_ff}));

   always_comb begin
      wall_kind = WALL_NONE;
      wall_row  = '0;
      wall_col  = '0;
      priority if (joined_ff && vert_adj) begin
         wall_kind = WALL_BELOW;
         wall_row  = (a_row_ff < b_row_ff) ? a_row_ff : b_row_ff;
         wall_col  = a_col_ff;
      end else if (joined_ff && horz_adj) begin
         wall_kind = WALL_RIGHT;
         wall_row  = a_row_ff;
         wall_col  = (a_col_ff < b_col_ff) ? a_col_ff : b_col_ff;
      end
   end

   // Saturate the set size to the result field
   assign msize_out = (32'(msize_ff) > 32'(MSIZE_MAX)) ? MSIZE_MAX : MSIZE_W'(msize_ff);

   assign last_hit = (({1'b0, edges_seen_ff} + 1'b1) >= {1'b0, edge_count_ff});

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == CELL_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_accept) state_in = in_bad ? ST_FINISH : ST_WALK_A;
         end
         ST_WALK_A: begin
            if (alu_eq) state_in = ST_WALK_B;
         end
         ST_WALK_B: begin
            if (alu_eq) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = alu_eq ? ST_FINISH : ST_MERGE;
         end
         ST_MERGE: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath control per state
   always_comb begin
      clr_idx_in    = clr_idx_ff;
      cur_in        = cur_ff;
      root_a_in     = root_a_ff;
      root_b_in     = root_b_ff;
      size_a_in     = size_a_ff;
      size_b_in     = size_b_ff;
      msize_in      = msize_ff;
      bad_in        = bad_ff;
      joined_in     = joined_ff;
      a_row_in      = a_row_ff;
      a_col_in      = a_col_ff;
      b_row_in      = b_row_ff;
      b_col_in      = b_col_ff;
      edges_seen_in = edges_seen_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      rsp_tvalid_in = rsp_tready ? 1'b0 : rsp_tvalid_ff;
      rd_addr       = cur_ff;
      wr            = '0;
      alu_a         = '0;
      alu_b         = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            // Make each cell its own root of size one
            wr.parent_we   = 1'b1;
            wr.parent_addr = clr_idx_ff;
            wr.parent_data = clr_idx_ff;
            wr.size_we     = 1'b1;
            wr.size_addr   = clr_idx_ff;
            wr.size_data   = SIZE_W'(1);
            clr_idx_in     = clr_idx_ff + 1'b1;
         end
         ST_IDLE: begin
            rd_addr = ca_req;
            if (req_accept) begin
               a_row_in  = in_ar;
               a_col_in  = in_ac;
               b_row_in  = in_br;
               b_col_in  = in_bc;
               bad_in    = in_bad;
               joined_in = 1'b0;
               msize_in  = '0;
               cur_in    = ca_req;
            end
         end
         ST_WALK_A: begin
            // Advance one link, or hold the root and start on cell b
            alu_a = OPND_W'(rd_parent);
            alu_b = OPND_W'(cur_ff);
            if (alu_eq) begin
               root_a_in = cur_ff;
               size_a_in = rd_size;
               cur_in    = cb_lat;
               rd_addr   = cb_lat;
            end else begin
               cur_in  = rd_parent;
               rd_addr = rd_parent;
            end
         end
         ST_WALK_B: begin
            alu_a = OPND_W'(rd_parent);
            alu_b = OPND_W'(cur_ff);
            if (alu_eq) begin
               root_b_in = cur_ff;
               size_b_in = rd_size;
            end else begin
               cur_in  = rd_parent;
               rd_addr = rd_parent;
            end
         end
         ST_DECIDE: begin
            // Same root: nothing to merge
            alu_a = OPND_W'(root_a_ff);
            alu_b = OPND_W'(root_b_ff);
            if (alu_eq) msize_in = size_a_ff;
         end
         ST_MERGE: begin
            // Link the smaller root under the larger; on a tie b joins a
            alu_a     = OPND_W'(size_a_ff);
            alu_b     = OPND_W'(size_b_ff);
            joined_in = 1'b1;
            msize_in  = SIZE_W'(alu_sum);
            wr.parent_we = 1'b1;
            wr.size_we   = 1'b1;
            wr.size_data = SIZE_W'(alu_sum);
            if (alu_lt) begin
               wr.parent_addr = root_a_ff;
               wr.parent_data = root_b_ff;
               wr.size_addr   = root_b_ff;
            end else begin
               wr.parent_addr = root_b_ff;
               wr.parent_data = root_a_ff;
               wr.size_addr   = root_a_ff;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_TDATA_W'({msize_out, wall_col, wall_row, joined_ff});
               rsp_tuser_in  = {bad_ff, wall_kind};
               rsp_tlast_in  = last_hit;
               edges_seen_in = last_hit ? '0 : EDGE_W'({1'b0, edges_seen_ff} + 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         edges_seen_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         edges_seen_ff <= edges_seen_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff  <= GRID_ROWS_RST;
         grid_cols_ff  <= GRID_COLS_RST;
         edge_count_ff <= EDGE_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_ROWS:  grid_rows_ff  <= csr_data[GRID_W-1:0];
            CSR_GRID_COLS:  grid_cols_ff  <= csr_data[GRID_W-1:0];
            CSR_EDGE_COUNT: edge_count_ff <= csr_data[EDGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      root_a_ff    <= root_a_in;
      root_b_ff    <= root_b_in;
      size_a_ff    <= size_a_in;
      size_b_ff    <= size_b_in;
      msize_ff     <= msize_in;
      bad_ff       <= bad_in;
      joined_ff    <= joined_in;
      a_row_ff     <= a_row_in;
      a_col_ff     <= a_col_in;
      b_row_ff     <= b_row_in;
      b_col_ff     <= b_col_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTHESIS
   // No result can appear while the stores are being cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_tvalid_ff)
      else $error("result valid during clearing pass");

   // A merge only ever joins two distinct roots
   a_merge_roots: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MERGE) |-> (root_a_ff != root_b_ff))
      else $error("merge of a root with itself");

   // A rejected edge reports no merge and no size
   a_bad_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tuser_ff[RSP_TUSER_W-1]) |->
      (!rsp_tdata_ff[0] && (rsp_tdata_ff[MSIZE_W+ROW_W+COL_W:ROW_W+COL_W+1] == '0)))
      else $error("bad edge result carries merge data");

   // A wall is only cleared by a merge
   a_wall_joined: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && (rsp_tuser_ff[1:0] != WALL_NONE)) |-> rsp_tdata_ff[0])
      else $error("wall cleared without a merge");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import ufmc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int TRAIL_CYCLES = 40;
   localparam int PRINT_CAP    = 40;
   localparam int HOLD_CYCLES  = 400;

   // One grid edge, packed as it travels on req_tdata (a_row in the lowest bits)
   typedef struct packed {
      logic [COL_W-1:0] b_col;
      logic [ROW_W-1:0] b_row;
      logic [COL_W-1:0] a_col;
      logic [ROW_W-1:0] a_row;
   } edge_item_type;

   typedef struct packed {
      logic                joined;
      wall_kind_type       wall_kind;
      logic [ROW_W-1:0]    wall_row;
      logic [COL_W-1:0]    wall_col;
      logic [MSIZE_W-1:0]  merged_size;
      logic                bad_cell;
      logic                last_edge;
   } carve_result_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [RSP_TUSER_W-1:0]  rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index  = CSR_GRID_ROWS;
   logic [CSR_DATA_W-1:0]   csr_data   = '0;

   union_find_maze_carver_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the disjoint sets and registers
   cell_type             link_of [CELLS];
   int unsigned          size_of [CELLS];
   logic [GRID_W-1:0]    grid_rows_q;
   logic [GRID_W-1:0]    grid_cols_q;
   logic [EDGE_W-1:0]    edge_count_q;
   int unsigned          edges_tally;

   carve_result_type     pending_results[$];
   int                   fail_count    = 0;
   int                   cycle_count   = 0;
   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   rsp_hold_left = 0;

   function automatic void clear_sets();
      for (int i = 0; i < CELLS; i++) begin
         link_of[i] = cell_type'(i);
         size_of[i] = 1;
      end
      edges_tally  = 0;
      grid_rows_q  = GRID_ROWS_RST;
      grid_cols_q  = GRID_COLS_RST;
      edge_count_q = EDGE_COUNT_RST;
   endfunction

   // Walk parent links up to the root, no compression
   function automatic cell_type root_of(input cell_type start);
      cell_type c;
      int       steps;
      c     = start;
      steps = 0;
      while (link_of[c] != c && steps < CELLS) begin
         c = link_of[c];
         steps++;
      end
      return c;
   endfunction

   function automatic cell_type cell_at(input int row, input int col);
      return cell_type'(row * MAX_COLS + col);
   endfunction

   // Apply one edge to the shadow sets and return the result it should give
   function automatic carve_result_type carve_predict(input edge_item_type e);
      int unsigned      rows;
      int unsigned      cols;
      int unsigned      msize;
      int               ar, ac, br, bc;
      cell_type         ra, rb;
      carve_result_type r;
      r     = '0;
      msize = 0;
      ar    = int'(e.a_row);
      ac    = int'(e.a_col);
      br    = int'(e.b_row);
      bc    = int'(e.b_col);
      rows  = (grid_rows_q < MAX_ROWS) ? grid_rows_q : MAX_ROWS;
      cols  = (grid_cols_q < MAX_COLS) ? grid_cols_q : MAX_COLS;
      if (ar >= rows || br >= rows || ac >= cols || bc >= cols) begin
         r.bad_cell = 1'b1;
      end else begin
         ra = root_of(cell_at(ar, ac));
         rb = root_of(cell_at(br, bc));
         if (ra == rb) begin
            msize = size_of[ra];
         end else begin
            r.joined = 1'b1;
            // smaller set joins the larger; on a tie b's root goes under a's
            if (size_of[ra] < size_of[rb]) begin
               link_of[ra] = rb;
               size_of[rb] += size_of[ra];
               msize = size_of[rb];
            end else begin
               link_of[rb] = ra;
               size_of[ra] += size_of[rb];
               msize = size_of[ra];
            end
            if (ac == bc && (ar + 1 == br || br + 1 == ar)) begin
               r.wall_kind = WALL_BELOW;
               r.wall_row  = ROW_W'((ar < br) ? ar : br);
               r.wall_col  = COL_W'(ac);
            end else if (ar == br && (ac + 1 == bc || bc + 1 == ac)) begin
               r.wall_kind = WALL_RIGHT;
               r.wall_row  = ROW_W'(ar);
               r.wall_col  = COL_W'((ac < bc) ? ac : bc);
            end
         end
         r.merged_size = (msize > MSIZE_MAX) ? MSIZE_MAX : MSIZE_W'(msize);
      end
      // every item counts towards the maze, bad or not
      if (edges_tally + 1 >= edge_count_q) begin
         r.last_edge = 1'b1;
         edges_tally = 0;
      end else begin
         edges_tally = (edges_tally + 1) & 32'h7FF;
      end
      return r;
   endfunction

   function automatic edge_item_type edge_of(input int ar, input int ac, input int br,
                                             input int bc);
      edge_item_type e;
      e.a_row = ROW_W'(ar);
      e.a_col = COL_W'(ac);
      e.b_row = ROW_W'(br);
      e.b_col = COL_W'(bc);
      return e;
   endfunction

   function automatic edge_item_type random_edge();
      return edge_of($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom_range(0, 31));
   endfunction

   // Random pair of neighbouring cells on the full grid, in either order
   function automatic edge_item_type random_neighbour_edge();
      int r, c;
      r = $urandom_range(0, 30);
      c = $urandom_range(0, 30);
      if ($urandom_range(0, 1))
         return $urandom_range(0, 1) ? edge_of(r, c, r + 1, c) : edge_of(r + 1, c, r, c);
      return $urandom_range(0, 1) ? edge_of(r, c, r, c + 1) : edge_of(r, c + 1, r, c);
   endfunction

   function automatic void set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 83;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            rsp_stall_pct = 83;
         end
         default: begin
            send_idle_pct = 18;
            rsp_stall_pct = 18;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int got_v, input int want_v);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("%0t ns: %s: got %0d, expected %0d", $time, what, got_v, want_v);
   endtask

   // Offer one edge, idling first at the current rate; predict on acceptance
   task automatic send_edge(input edge_item_type e);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {{(REQ_TDATA_W - $bits(edge_item_type)){1'b0}}, e};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_results.push_back(carve_predict(e));
   endtask

   // Drop the request and hold until every expected result is back
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   // Write all three registers back to back; callers make sure the block is idle
   task automatic configure(input logic [CSR_DATA_W-1:0] rows,
                            input logic [CSR_DATA_W-1:0] cols,
                            input logic [CSR_DATA_W-1:0] count);
      csr_index_type         order  [3] = '{CSR_GRID_ROWS, CSR_GRID_COLS, CSR_EDGE_COUNT};
      logic [CSR_DATA_W-1:0] values [3];
      values = '{rows, cols, count};
      for (int i = 0; i < 3; i++) begin
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_data  <= values[i];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         case (order[i])
            CSR_GRID_ROWS:  grid_rows_q  = values[i][GRID_W-1:0];
            CSR_GRID_COLS:  grid_cols_q  = values[i][GRID_W-1:0];
            CSR_EDGE_COUNT: edge_count_q = values[i][EDGE_W-1:0];
            default: ;
         endcase
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Both wall kinds in both orders, corners, repeats, a tie and far merges
   task automatic test_walls_and_merges();
      set_idle_mode(IDLE_NONE);
      send_edge(edge_of(0, 0, 1, 0));
      send_edge(edge_of(0, 1, 0, 0));
      send_edge(edge_of(0, 0, 0, 0));
      send_edge(edge_of(1, 0, 0, 1));
      send_edge(edge_of(31, 31, 30, 31));
      send_edge(edge_of(31, 30, 31, 31));
      send_edge(edge_of(10, 10, 10, 11));
      send_edge(edge_of(12, 12, 12, 13));
      send_edge(edge_of(10, 10, 12, 12));
      send_edge(edge_of(5, 5, 20, 17));
      send_edge(edge_of(31, 0, 0, 31));
      send_edge(edge_of(0, 0, 31, 31));
   endtask

   // Each endpoint field in turn past the grid in use (a fields just past, b fields at 31), then an edge inside it
   task automatic test_bad_endpoints();
      wait_for_results();
      configure(6, 9, 2047);
      send_edge(edge_of(6, 0, 0, 0));
      send_edge(edge_of(0, 9, 0, 0));
      send_edge(edge_of(0, 0, 31, 0));
      send_edge(edge_of(0, 0, 0, 31));
      send_edge(edge_of(5, 8, 4, 8));
   endtask

   // Empty grid, one-cell grid, and register values beyond the built size
   task automatic test_grid_extremes();
      wait_for_results();
      configure(0, 2, 2047);
      send_edge(edge_of(0, 0, 0, 1));
      wait_for_results();
      configure(11'h7FF, 40, 2047);
      send_edge(edge_of(31, 31, 31, 30));
      send_edge(edge_of(30, 0, 31, 0));
      wait_for_results();
      configure(1, 1, 2047);
      send_edge(edge_of(0, 0, 0, 0));
   endtask

   // Edge count of zero marks every item; one and three mark on the count
   task automatic test_edge_marks();
      wait_for_results();
      configure(2, 2, 0);
      send_edge(edge_of(0, 0, 0, 1));
      send_edge(edge_of(1, 1, 1, 0));
      wait_for_results();
      configure(2, 2, 1);
      send_edge(edge_of(1, 0, 0, 0));
      wait_for_results();
      configure(2, 2, 3);
      send_edge(edge_of(0, 1, 1, 1));
      send_edge(edge_of(2, 0, 0, 0));
      send_edge(edge_of(0, 0, 1, 1));
   endtask

   // Hold the result side off while items keep coming, then stall it at random
   task automatic test_backpressure();
      wait_for_results();
      configure(32, 32, 1984);
      set_idle_mode(IDLE_NONE);
      rsp_hold_left = HOLD_CYCLES;
      for (int i = 0; i < 40; i++)
         send_edge(random_neighbour_edge());
      wait_for_results();
      set_idle_mode(IDLE_RECEIVER);
      for (int i = 0; i < 20; i++)
         send_edge(random_neighbour_edge());
   endtask

   // Kruskal-style carving over growing grids: shuffled edges of the grid,
   // sending those that join, some that do not, and a little noise
   task automatic test_carving();
      int            grid_rows_list [4] = '{4, 6, 10, 32};
      int            grid_cols_list [4] = '{4, 8, 8, 32};
      int            counts         [4];
      edge_item_type edges[$];
      edge_item_type e;
      int            j;
      int            sent;
      counts = '{7, 0, $urandom_range(1, 60), 1984};
      sent   = 0;
      for (int p = 0; p < 4; p++) begin
         wait_for_results();
         configure(CSR_DATA_W'(grid_rows_list[p]), CSR_DATA_W'(grid_cols_list[p]),
                   CSR_DATA_W'(counts[p]));
         edges.delete();
         for (int r = 0; r < grid_rows_list[p]; r++) begin
            for (int c = 0; c < grid_cols_list[p]; c++) begin
               if (r + 1 < grid_rows_list[p])
                  edges.push_back(edge_of(r, c, r + 1, c));
               if (c + 1 < grid_cols_list[p])
                  edges.push_back(edge_of(r, c, r, c + 1));
            end
         end
         for (int i = edges.size() - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            e        = edges[i];
            edges[i] = edges[j];
            edges[j] = e;
         end
         foreach (edges[i]) begin
            set_idle_mode(idle_mode_type'((sent / 90) % 4));
            if ($urandom_range(0, 99) < 4) begin
               send_edge(random_edge());
               sent++;
            end
            e = edges[i];
            if ($urandom_range(0, 1))
               e = edge_of(e.b_row, e.b_col, e.a_row, e.a_col);
            if (root_of(cell_at(e.a_row, e.a_col)) != root_of(cell_at(e.b_row, e.b_col))
                || $urandom_range(0, 99) < 8) begin
               send_edge(e);
               sent++;
            end
         end
      end
   endtask

   // Result side: random stalls, or a counted hold-off when one is asked for
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      carve_result_type got;
      carve_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.joined      = rsp_tdata[0];
         got.wall_row    = rsp_tdata[5:1];
         got.wall_col    = rsp_tdata[10:6];
         got.merged_size = rsp_tdata[21:11];
         got.wall_kind   = wall_kind_type'(rsp_tuser[1:0]);
         got.bad_cell    = rsp_tuser[2];
         got.last_edge   = rsp_tlast;
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (got.joined !== want.joined)
               report_mismatch("joined", got.joined, want.joined);
            if (got.wall_kind !== want.wall_kind)
               report_mismatch("wall_kind", got.wall_kind, want.wall_kind);
            if (got.wall_row !== want.wall_row)
               report_mismatch("wall_row", got.wall_row, want.wall_row);
            if (got.wall_col !== want.wall_col)
               report_mismatch("wall_col", got.wall_col, want.wall_col);
            if (got.merged_size !== want.merged_size)
               report_mismatch("merged_size", got.merged_size, want.merged_size);
            if (got.bad_cell !== want.bad_cell)
               report_mismatch("bad_cell", got.bad_cell, want.bad_cell);
            if (got.last_edge !== want.last_edge)
               report_mismatch("last_edge", got.last_edge, want.last_edge);
         end
      end
   end

   // Give up on a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      clear_sets();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_walls_and_merges();
      test_bad_endpoints();
      test_grid_extremes();
      test_edge_marks();
      test_backpressure();
      test_carving();

      wait_for_results();
      repeat (TRAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
